### rtl/tmf_pkg.sv
// Package with the constants and the neighbor link type of the temporal median filter.
`timescale 1ns / 1ps

package tmf_pkg;

    localparam int HALF_WINDOW = 10;
    localparam int WIN_LEN     = 2 * HALF_WINDOW + 1;
    localparam int DATA_W      = 8;
    localparam int AGE_W       = $clog2(WIN_LEN);

    localparam logic [AGE_W-1:0] OLDEST_AGE = AGE_W'(WIN_LEN - 1);

    // What one cell shows its neighbors: its stored sample and age, whether that
    // sample is greater than the incoming one, and whether the oldest entry sits
    // at or to the left of this cell.
    typedef struct packed {
        logic [DATA_W-1:0] val;
        logic [AGE_W-1:0]  age;
        logic              gt;
        logic              dl;
    } tmf_link_t;

endpackage

### rtl/temporal_median_filter.sv
// Top level of the temporal median filter: a sorted chain of cells and the output handshake.
`timescale 1ns / 1ps
//
// Running median over the last 21 samples of one pixel position.
//
// Input channel: in_valid, in_stall and sample. An item is accepted at a rising edge where
// in_valid is high and in_stall is low. Output channel: out_valid, out_stall and median, with
// the same rule; the receiver drives out_stall.
//
// Every accepted item yields exactly one result, the sample of rank ten in ascending order
// among the last 21 samples including the new one. The window is kept as a row of 21 cells in
// sorted order, each cell also holding the age of its sample. On each item the oldest sample
// leaves, the new one is placed at its rank, and every cell takes its next content from
// itself, a neighbor or the incoming sample, all in the same update.
//
// The result is valid in the cycle after the item is accepted, read straight from the middle
// cell. The block takes one item per cycle unless the receiver stalls, since the cell row
// updates on every accepted item. While out_stall holds a result, in_stall is
// raised and the cells keep their contents, so the result stays stable.
//
// Reset clears every cell to zero, which stands for the frames before the stream starts, so
// the first ten results are zero. No clearing pass is needed after reset.

module temporal_median_filter (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [tmf_pkg::DATA_W-1:0]  sample,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [tmf_pkg::DATA_W-1:0]  median
);
    import tmf_pkg::*;

    logic      accept;
    logic      out_valid_reg;
    logic      out_valid_next;

    // Link k is the output of cell k-1; link 0 and the last link are the fixed ends of the row.
    tmf_link_t lnk [0:WIN_LEN+1];

    // The left end never holds a greater sample and never holds the oldest one.
    assign lnk[0] = '{val: '0, age: '0, gt: 1'b0, dl: 1'b0};
    // The right end always counts as greater, so the last cell never pulls from it.
    assign lnk[WIN_LEN+1] = '{val: '0, age: '0, gt: 1'b1, dl: 1'b1};

    // A held result blocks new items so the middle cell keeps its value.
    assign in_stall = out_valid_reg & out_stall;
    assign accept   = in_valid & ~in_stall;

    genvar i;
    generate
        for (i = 0; i < WIN_LEN; i++)
        begin : g_cell
            tmf_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .enable    (accept),
                .sample    (sample),
                .reset_age (AGE_W'(i)),
                .left      (lnk[i]),
                .right     (lnk[i+2]),
                .link      (lnk[i+1])
            );
        end
    endgenerate

    assign out_valid_next = accept | (out_valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign median    = lnk[HALF_WINDOW+1].val;

endmodule

### rtl/tmf_cell.sv
// One cell of the sorted window: holds one sample and its age, and takes its next content from
// itself, a neighbor or the incoming sample.
`timescale 1ns / 1ps

module tmf_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        enable,
    input  logic [tmf_pkg::DATA_W-1:0]  sample,
    input  logic [tmf_pkg::AGE_W-1:0]   reset_age,
    input  tmf_pkg::tmf_link_t          left,
    input  tmf_pkg::tmf_link_t          right,
    output tmf_pkg::tmf_link_t          link
);
    import tmf_pkg::*;

    logic [DATA_W-1:0] val_reg;
    logic [DATA_W-1:0] val_next;
    logic [AGE_W-1:0]  age_reg;
    logic [AGE_W-1:0]  age_next;
    logic              gt;
    logic              del;
    logic              dl;
    logic [DATA_W-1:0] src_val;
    logic [AGE_W-1:0]  src_age;
    logic              take_new;

    assign gt  = val_reg > sample;
    assign del = age_reg == OLDEST_AGE;
    assign dl  = left.dl | del;

    assign link = '{val: val_reg, age: age_reg, gt: gt, dl: dl};

    always_comb
    begin
        take_new = 1'b0;
        src_val  = val_reg;
        src_age  = age_reg;
        if (!dl)
        begin
            // The oldest entry lies to the right: only the insertion shifts things right.
            if (gt)
            begin
                if (left.gt)
                begin
                    src_val = left.val;
                    src_age = left.age;
                end
                else
                begin
                    take_new = 1'b1;
                end
            end
        end
        else if (!right.gt)
        begin
            src_val = right.val;
            src_age = right.age;
        end
        else if (del)
        begin
            if (left.gt)
            begin
                src_val = left.val;
                src_age = left.age;
            end
            else
            begin
                take_new = 1'b1;
            end
        end
        else if (!gt)
        begin
            take_new = 1'b1;
        end

        if (take_new)
        begin
            val_next = sample;
            age_next = '0;
        end
        else
        begin
            val_next = src_val;
            age_next = src_age + AGE_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg <= '0;
            age_reg <= reset_age;
        end
        else if (enable)
        begin
            val_reg <= val_next;
            age_reg <= age_next;
        end
    end

endmodule

### tb/tmf_median_checker.sv
// Checker that predicts the running median of every accepted sample and compares each result.
`timescale 1ns / 1ps

module tmf_median_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic [tmf_pkg::DATA_W-1:0]  sample,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic [tmf_pkg::DATA_W-1:0]  median,
    output int                          mismatches,
    output int                          pending
);

    import tmf_pkg::*;

    // Last WIN_LEN samples, oldest at index 0.
    logic [DATA_W-1:0] recent_samples [WIN_LEN];
    logic [DATA_W-1:0] due_medians [$];
    int                mismatch_tally;

    // The middle value is the one with at most HALF_WINDOW entries strictly below it
    // and more than HALF_WINDOW entries at or below it.
    function automatic logic [DATA_W-1:0] window_middle();
        int below;
        int not_above;
        for (int i = 0; i < WIN_LEN; i++)
        begin
            below     = 0;
            not_above = 0;
            for (int j = 0; j < WIN_LEN; j++)
            begin
                if (recent_samples[j] < recent_samples[i])
                    below++;
                if (recent_samples[j] <= recent_samples[i])
                    not_above++;
            end
            if (below <= HALF_WINDOW && not_above > HALF_WINDOW)
                return recent_samples[i];
        end
        return '0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        logic [DATA_W-1:0] want;
        if (!rst_n)
        begin
            for (int i = 0; i < WIN_LEN; i++)
                recent_samples[i] = '0;
            due_medians.delete();
            mismatch_tally = 0;
            mismatches <= 0;
            pending    <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                for (int i = 0; i < WIN_LEN - 1; i++)
                    recent_samples[i] = recent_samples[i + 1];
                recent_samples[WIN_LEN - 1] = sample;
                due_medians.push_back(window_middle());
            end
            if (out_valid && !out_stall)
            begin
                if (due_medians.size() == 0)
                begin
                    $error("median: expected none, actual %0d", median);
                    mismatch_tally++;
                end
                else
                begin
                    want = due_medians.pop_front();
                    if (median !== want)
                    begin
                        $error("median: expected %0d, actual %0d", want, median);
                        mismatch_tally++;
                    end
                end
            end
            mismatches <= mismatch_tally;
            pending    <= due_medians.size();
        end
    end

endmodule

### tb/temporal_median_filter_tb.sv
// Top of the temporal median filter testbench: clock, reset, sample stimulus and verdict.
`timescale 1ns / 1ps

module temporal_median_filter_tb;

    import tmf_pkg::*;

    localparam int ITEMS          = 1800;
    // The closing stretch of the run is sent with no idling on either side.
    localparam int CALM_ITEMS     = 200;
    // Long receiver hold-off that fills the block and pushes back on the sender.
    localparam int HOLD_CYCLES    = 300;
    // Cycles with no accepted item before the run is declared hung. The longest
    // correct quiet stretch is the hold-off plus a burst of idling on each side.
    localparam int WATCHDOG_LIMIT = 2000;
    // The block answers in the cycle after an item is taken, so DRAIN_CYCLES of
    // settling at the end are plenty to catch a stray extra result.
    localparam int DRAIN_CYCLES   = 8;

    // Shapes of the random sample stream. Most mimic what a pixel over time does
    // in practice: a steady level with occasional flicker, slow drift, noise.
    typedef enum int {
        SHAPE_UNIFORM,
        SHAPE_IMPULSE,
        SHAPE_NARROW,
        SHAPE_RAMP,
        SHAPE_TWO_LEVEL
    } stream_shape_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    logic [DATA_W-1:0] sample    = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [DATA_W-1:0] median;

    int                mismatches;
    int                pending;
    // Chance in percent that a burst of idling starts; shared by both sides.
    int                idle_pct  = 0;
    logic              hold_go   = 1'b0;
    int                quiet_cycles = 0;

    always #5 clk = ~clk;

    temporal_median_filter uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .sample    (sample),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .median    (median)
    );

    tmf_median_checker median_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample     (sample),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .median     (median),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // Offer one sample and hold it until the block takes it. A burst of idling
    // may come first. The valid stays high from one item to the next when there
    // is no gap, so it only ever gets one assignment per clock edge.
    task automatic send_sample(input logic [DATA_W-1:0] level);
        int gap;
        if ($urandom_range(0, 99) < idle_pct)
        begin
            gap = $urandom_range(1, 19);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= level;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Receiver side. It stalls in bursts while idling is enabled, and once in the
    // run it holds off for a long stretch so that the block backs up.
    initial
    begin : receiver
        int burst;
        logic held;
        held = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_go && !held)
            begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if ($urandom_range(0, 99) < idle_pct)
            begin
                burst = $urandom_range(1, 19);
                out_stall <= 1'b1;
                repeat (burst) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // A hung handshake shows up as a long run of cycles in which neither side
    // moves an item.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles + 1 >= WATCHDOG_LIMIT)
            begin
                $display("temporal_median_filter regression: fail");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        stream_shape_t     shape;
        int                seg_len;
        int                sent;
        logic [DATA_W-1:0] base;
        logic [DATA_W-1:0] level;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. At the start of the stream the reset zeros count as
        // real samples, so a run of full-scale samples only lifts the median
        // once it outnumbers them: the run's first ten results stay at zero and
        // its eleventh flips to full scale. Then alternating bit patterns and
        // values next to both ends, and a run of zeros to pull it back down.
        idle_pct = 15;
        send_sample(8'd0);
        repeat (11) send_sample(8'd255);
        send_sample(8'hAA);
        send_sample(8'h55);
        send_sample(8'd1);
        send_sample(8'd254);
        send_sample(8'd128);
        send_sample(8'd127);
        repeat (7) send_sample(8'd0);

        // Random part, in segments of one stream shape each. The idle rate also
        // changes per segment so that some stretches run with no gaps at all.
        sent = 0;
        while (sent < ITEMS - CALM_ITEMS)
        begin
            shape   = stream_shape_t'($urandom_range(0, 4));
            seg_len = $urandom_range(20, 90);
            base    = DATA_W'($urandom);
            case ($urandom_range(0, 2))
                0:       idle_pct = 0;
                1:       idle_pct = 10;
                default: idle_pct = 35;
            endcase
            for (int k = 0; k < seg_len; k++)
            begin
                case (shape)
                    SHAPE_UNIFORM:   level = DATA_W'($urandom);
                    SHAPE_IMPULSE:   level = ($urandom_range(0, 9) == 0) ? DATA_W'($urandom)
                                                                        : base;
                    SHAPE_NARROW:    level = base + DATA_W'($urandom_range(0, 6)) - 8'd3;
                    SHAPE_RAMP:      level = base + DATA_W'(k * 3);
                    default:         level = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
                endcase
                send_sample(level);
            end
            sent += seg_len;
            // Somewhere in the middle of the run the receiver backs off for a
            // long while; the sender keeps offering items meanwhile.
            if (!hold_go && sent > 500)
                hold_go <= 1'b1;
        end

        // Closing stretch at full rate on both sides.
        idle_pct = 0;
        for (int k = 0; k < CALM_ITEMS; k++)
        begin
            if ($urandom_range(0, 1) == 1)
                level = DATA_W'($urandom);
            else
                level = ($urandom_range(0, 7) == 0) ? DATA_W'($urandom) : 8'd90;
            send_sample(level);
        end
        in_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending == 0)
            $display("temporal_median_filter regression: pass");
        else
            $display("temporal_median_filter regression: fail");
        $finish;
    end

endmodule

### temporal_median_filter.f
rtl/tmf_pkg.sv
rtl/tmf_cell.sv
rtl/temporal_median_filter.sv
tb/tmf_median_checker.sv
tb/temporal_median_filter_tb.sv
